[src/countdown_timer_with_presets_defines.svh]
// Assertion macros for the countdown timer with presets.
// Included by the top level; expects clk and rst_n in scope.
`ifndef COUNTDOWN_TIMER_WITH_PRESETS_DEFINES_SVH
`define COUNTDOWN_TIMER_WITH_PRESETS_DEFINES_SVH
`ifndef SYNTHESIS
`define CDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CDT_ASSERT_NOW(lbl, ante, cons, msg)
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/cdt_pkg.sv]
// Package for the countdown timer with presets: widths, register indexes,
// reset values, mode encodings and the mode code function. No dependencies.
package cdt_pkg;

  localparam int FP_W       = 17;
  localparam int TPS_W      = 4;
  localparam int BLINK_W    = 4;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 3;

  localparam int SECONDS_BITS_DEF = 17;
  localparam int PHASE_BITS_DEF   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_PERIOD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_TICKS   = 2'd2;

  localparam logic [FP_W-1:0]    FULL_PERIOD_RST = 17'd86400;
  localparam logic [TPS_W-1:0]   TPS_RST         = 4'd10;
  localparam logic [BLINK_W-1:0] BLINK_RST       = 4'd5;

  localparam logic [FP_W-1:0] STEP_HOUR = 17'd3600;
  localparam logic [FP_W-1:0] STEP_MIN  = 17'd60;

  localparam logic [MODE_W-1:0] MODE_CODE_HOUR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_MIN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_SEC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_RUN   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_PAUSE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_END   = 3'd5;

  typedef enum logic [5:0] {
    MODE_HOUR  = 6'b000001,
    MODE_MIN   = 6'b000010,
    MODE_SEC   = 6'b000100,
    MODE_RUN   = 6'b001000,
    MODE_PAUSE = 6'b010000,
    MODE_END   = 6'b100000
  } mode_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_HOUR:  c = MODE_CODE_HOUR;
      MODE_MIN:   c = MODE_CODE_MIN;
      MODE_SEC:   c = MODE_CODE_SEC;
      MODE_RUN:   c = MODE_CODE_RUN;
      MODE_PAUSE: c = MODE_CODE_PAUSE;
      default:    c = MODE_CODE_END;
    endcase
    return c;
  endfunction

endpackage

[src/countdown_timer_with_presets.sv]
// Top level of the countdown timer with presets: tick update, preset
// stepping, modulus reduction sequencer and a two-entry result buffer.
// Depends on cdt_pkg and countdown_timer_with_presets_defines.svh.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  four button levels
//   out      output     out_valid/out_ready mode, times, alarm, blank
//   cfg      input      cfg_wr_en          cfg_index, cfg_wdata
//
// Each tick transfer's result is registered into the result buffer, so
// one tick per cycle is sustained while no pass runs and the buffer has room.
// A write of a nonzero full_period starts a reduction pass in the
// shift-subtract lanes; in_ready is low during the pass.
// The result buffer holds two entries; in_ready falls when both are full.
// Reset is synchronous and active low; no pass runs after reset.
`include "countdown_timer_with_presets_defines.svh"

module countdown_timer_with_presets
  import cdt_pkg::*;
#(
  parameter int SECONDS_BITS = SECONDS_BITS_DEF,
  parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_start_set_pressed,
  input  logic                    in_field_reset_pressed,
  input  logic                    in_up_run_pressed,
  input  logic                    in_down_lap_pressed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [MODE_W-1:0]       out_mode_now,
  output logic [SECONDS_BITS-1:0] out_remaining_seconds,
  output logic [SECONDS_BITS-1:0] out_lap_seconds,
  output logic [SECONDS_BITS-1:0] out_preset_seconds,
  output logic                    out_alarm_on,
  output logic                    out_field_blank,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DIV_BITS = (SECONDS_BITS > FP_W) ? SECONDS_BITS : FP_W;
  localparam int CNT_W    = $clog2(DIV_BITS + 1);
  localparam int CMP_W    = (PHASE_BITS > TPS_W) ? PHASE_BITS : TPS_W;
  localparam int RES_W    = MODE_W + 3 * SECONDS_BITS + 2;
  localparam int LANES    = 3;

  logic [FP_W-1:0]    full_period_r;
  logic [TPS_W-1:0]   tps_r;
  logic [BLINK_W-1:0] blink_r;

  logic [PHASE_BITS-1:0]   phase_r;
  mode_t                   mode_r;
  logic [SECONDS_BITS-1:0] remaining_r;
  logic [SECONDS_BITS-1:0] lap_r;
  logic [SECONDS_BITS-1:0] preset_r;
  logic [3:0]              prev_r;

  logic [FP_W-1:0] pm_r;
  logic [FP_W-1:0] up_hr_r;
  logic [FP_W-1:0] up_mn_r;
  logic [FP_W-1:0] up_sc_r;
  logic [FP_W-1:0] dn_hr_r;
  logic [FP_W-1:0] dn_mn_r;
  logic [FP_W-1:0] dn_sc_r;

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIV_BITS-1:0] dvd_r [LANES];
  logic [FP_W-1:0]     rem_r [LANES];
  logic [FP_W:0]       lane_sub [LANES];

  logic [RES_W-1:0] main_r;
  logic [RES_W-1:0] skid_r;
  logic             main_v_r;
  logic             skid_v_r;

  logic                    push;
  logic                    pop;
  logic                    period_wr;
  logic [3:0]              cur;
  logic [3:0]              rel;
  logic [PHASE_BITS-1:0]   ph_inc;
  logic                    sec_done;
  logic [PHASE_BITS-1:0]   phase_nxt;
  mode_t                   mode_a;
  mode_t                   mode_b;
  mode_t                   mode_nxt;
  logic [SECONDS_BITS-1:0] rem_a;
  logic [SECONDS_BITS-1:0] remaining_nxt;
  logic [SECONDS_BITS-1:0] lap_nxt;
  logic [SECONDS_BITS-1:0] preset_nxt;
  logic [FP_W-1:0]         pm_nxt;
  logic                    editing;
  logic                    req_any;
  logic                    act_up;
  logic                    act_dn;
  logic [FP_W-1:0]         up_sel;
  logic [FP_W-1:0]         dn_sel;
  logic [FP_W-1:0]         addend;
  logic [FP_W:0]           step_sum;
  logic [FP_W:0]           step_wrap;
  logic [FP_W-1:0]         step_res;
  logic                    alarm_nxt;
  logic                    blank_nxt;
  logic [RES_W-1:0]        res_nxt;

  assign in_ready  = !busy_r && !skid_v_r;
  assign push      = in_valid && in_ready;
  assign pop       = main_v_r && out_ready;
  assign period_wr = cfg_wr_en && (cfg_index == CFG_FULL_PERIOD);

  always_comb begin
    cur = {in_down_lap_pressed, in_up_run_pressed, in_field_reset_pressed,
           in_start_set_pressed};
    rel = prev_r & ~cur;

    ph_inc    = phase_r + 1'b1;
    sec_done  = CMP_W'(ph_inc) >= CMP_W'(tps_r);
    phase_nxt = sec_done ? '0 : ph_inc;
    mode_a    = mode_r;
    rem_a     = remaining_r;
    if (sec_done && mode_r == MODE_RUN) begin
      if (remaining_r == '0) begin
        mode_a = MODE_END;
      end else begin
        rem_a = remaining_r - 1'b1;
      end
    end

    editing = (mode_a == MODE_HOUR) || (mode_a == MODE_MIN) || (mode_a == MODE_SEC);
    req_any = rel[0] || (rel[1] && !editing);
    act_up  = rel[2] && !req_any;
    act_dn  = rel[3] && !req_any;

    mode_b = mode_a;
    if (rel[1] && !rel[0] && editing) begin
      case (mode_a)
        MODE_HOUR: mode_b = MODE_MIN;
        MODE_MIN:  mode_b = MODE_SEC;
        default:   mode_b = MODE_HOUR;
      endcase
    end

    mode_nxt = mode_b;
    if (act_up && !editing) begin
      case (mode_b)
        MODE_RUN:   mode_nxt = MODE_PAUSE;
        MODE_PAUSE: mode_nxt = MODE_RUN;
        default:    mode_nxt = mode_b;
      endcase
    end

    // Up and down in the same tick cancel, leaving the reduced preset.
    case (mode_b)
      MODE_HOUR: begin
        up_sel = up_hr_r;
        dn_sel = dn_hr_r;
      end
      MODE_MIN: begin
        up_sel = up_mn_r;
        dn_sel = dn_mn_r;
      end
      default: begin
        up_sel = up_sc_r;
        dn_sel = dn_sc_r;
      end
    endcase
    addend    = (act_up && act_dn) ? '0 : (act_up ? up_sel : dn_sel);
    step_sum  = {1'b0, pm_r} + {1'b0, addend};
    step_wrap = (step_sum >= {1'b0, full_period_r}) ?
                (step_sum - {1'b0, full_period_r}) : step_sum;
    step_res  = (full_period_r == '0) ? '0 : step_wrap[FP_W-1:0];

    preset_nxt = preset_r;
    pm_nxt     = pm_r;
    if (editing && (act_up || act_dn)) begin
      preset_nxt = SECONDS_BITS'(step_res);
      pm_nxt     = FP_W'(SECONDS_BITS'(step_res));
    end

    lap_nxt       = lap_r;
    remaining_nxt = rem_a;
    if (act_dn && !editing) begin
      lap_nxt = rem_a;
    end

    if (req_any) begin
      phase_nxt     = '0;
      lap_nxt       = '0;
      remaining_nxt = preset_r;
      mode_nxt      = (rel[0] && !editing) ? MODE_HOUR : MODE_PAUSE;
    end

    alarm_nxt = (mode_nxt == MODE_END) && (CMP_W'(phase_nxt) <= CMP_W'(blink_r));
    blank_nxt = ((mode_nxt == MODE_HOUR) || (mode_nxt == MODE_MIN) ||
                 (mode_nxt == MODE_SEC)) && (CMP_W'(phase_nxt) > CMP_W'(blink_r));
    res_nxt   = {mode_code(mode_nxt), remaining_nxt, lap_nxt, preset_nxt,
                 alarm_nxt, blank_nxt};
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_sub[i] = {rem_r[i], dvd_r[i][DIV_BITS-1]};
      if (lane_sub[i] >= {1'b0, full_period_r}) begin
        lane_sub[i] = lane_sub[i] - {1'b0, full_period_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_period_r <= FULL_PERIOD_RST;
      tps_r         <= TPS_RST;
      blink_r       <= BLINK_RST;
      phase_r       <= '0;
      mode_r        <= MODE_PAUSE;
      remaining_r   <= '0;
      lap_r         <= '0;
      preset_r      <= '0;
      prev_r        <= '0;
      pm_r          <= '0;
      up_hr_r       <= STEP_HOUR;
      up_mn_r       <= STEP_MIN;
      up_sc_r       <= FP_W'(1);
      dn_hr_r       <= FULL_PERIOD_RST - STEP_HOUR;
      dn_mn_r       <= FULL_PERIOD_RST - STEP_MIN;
      dn_sc_r       <= FULL_PERIOD_RST - FP_W'(1);
      busy_r        <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (push) begin
        phase_r     <= phase_nxt;
        mode_r      <= mode_nxt;
        remaining_r <= remaining_nxt;
        lap_r       <= lap_nxt;
        preset_r    <= preset_nxt;
        pm_r        <= pm_nxt;
        prev_r      <= cur;
      end

      if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_BITS)) begin
          pm_r    <= rem_r[0];
          up_hr_r <= rem_r[1];
          up_mn_r <= rem_r[2];
          dn_hr_r <= full_period_r - rem_r[1];
          dn_mn_r <= full_period_r - rem_r[2];
          busy_r  <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FULL_PERIOD: begin
            full_period_r <= cfg_wdata;
            busy_r        <= (cfg_wdata != '0);
            cnt_r         <= '0;
            up_sc_r       <= (cfg_wdata == FP_W'(1)) ? '0 : FP_W'(1);
            dn_sc_r       <= (cfg_wdata == FP_W'(1)) ? FP_W'(1) : cfg_wdata - 1'b1;
          end
          CFG_TICKS_PER_SECOND: tps_r   <= cfg_wdata[TPS_W-1:0];
          CFG_BLINK_ON_TICKS:   blink_r <= cfg_wdata[BLINK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Shift-subtract remainder lanes: reduced preset, hour step, minute step.
  always_ff @(posedge clk) begin
    if (period_wr) begin
      dvd_r[0] <= DIV_BITS'(preset_r);
      dvd_r[1] <= DIV_BITS'(STEP_HOUR);
      dvd_r[2] <= DIV_BITS'(STEP_MIN);
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= '0;
      end
    end else if (busy_r && cnt_r != CNT_W'(DIV_BITS)) begin
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= lane_sub[i][FP_W-1:0];
        dvd_r[i] <= dvd_r[i] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          main_v_r <= push;
        end
      end else if (push) begin
        if (!main_v_r) begin
          main_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_v_r)) begin
      main_r <= res_nxt;
    end
    if (push && main_v_r && !pop) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid             = main_v_r;
  assign out_mode_now          = main_r[RES_W-1 -: MODE_W];
  assign out_remaining_seconds = main_r[2 + 3 * SECONDS_BITS - 1 -: SECONDS_BITS];
  assign out_lap_seconds       = main_r[2 + 2 * SECONDS_BITS - 1 -: SECONDS_BITS];
  assign out_preset_seconds    = main_r[2 + SECONDS_BITS - 1 -: SECONDS_BITS];
  assign out_alarm_on          = main_r[1];
  assign out_field_blank       = main_r[0];

  `CDT_ASSERT_NOW(a_pass_blocks_input, busy_r, !in_ready, "tick accepted during reduction pass")
  `CDT_ASSERT_NOW(a_skid_needs_main, skid_v_r, main_v_r, "skid entry without main entry")
  `CDT_ASSERT_NEXT(a_pass_go, period_wr && |cfg_wdata, busy_r && cnt_r == '0, "pass did not start")
  `CDT_ASSERT_NOW(a_mode_onehot, 1'b1, $onehot(mode_r), "mode register not one-hot")
  `CDT_ASSERT_NOW(a_alarm_end, alarm_nxt, mode_nxt == MODE_END && !blank_nxt, "alarm outside end")

endmodule
